@@ hdl/u2u_pkg.sv @@
// Shared types, operation codes and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none
package u2u_pkg;

   localparam int ByteWidth = 8;
   localparam int UnitWidth = 16;
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [UnitWidth-1:0] REPLACEMENT_UNIT = 16'hFFFD;

   // Operation codes handed from the front to the back.
   localparam int OpWidth = 2;
   localparam logic [OpWidth-1:0] OP_LONE  = 2'd0; // byte decoded on its own
   localparam logic [OpWidth-1:0] OP_TWO   = 2'd1; // two-byte sequence complete
   localparam logic [OpWidth-1:0] OP_THREE = 2'd2; // three-byte sequence complete
   localparam logic [OpWidth-1:0] OP_TRUNC = 2'd3; // truncated lead, then lone final byte

   typedef struct packed {
      logic [OpWidth-1:0]   op;
      logic [ByteWidth-1:0] lead;
      logic [ByteWidth-1:0] second;
      logic [ByteWidth-1:0] data;
      logic                 last;
   } entry_type;

   function automatic logic is_three_lead(input logic [ByteWidth-1:0] b);
      return (b & 8'hF0) == 8'hE0;
   endfunction

   function automatic logic is_two_lead(input logic [ByteWidth-1:0] b);
      return (b & 8'hE0) == 8'hC0;
   endfunction

endpackage
`default_nettype wire

@@ hdl/utf8_to_utf16_decoder.sv @@
// Top level of the UTF-8 to UTF-16 (BMP) decoder.
// Usage:
//   req_* carries one UTF-8 byte per item in req_tdata[7:0]; req_tlast marks
//   the final byte of a string. rsp_* returns 16-bit code units in rsp_tdata;
//   rsp_tlast marks the final unit of the string.
//   Throughput: one byte per cycle while req_tready is high. Lead bytes produce
//   no unit unless they end the string; the byte that completes a sequence gives
//   one. A three-byte lead with only one byte after it in the string gives two
//   units (0xFFFD, then the final byte alone), sent in turn by the back end.
//   A unit reaches rsp_* through the queue and then the output register.
//   A four-entry queue sits between the byte classifier and the unit builder;
//   req_tready drops only when it is full, so a stalled receiver backs up
//   through the output register and queue before the input stalls.
//   Reset (synchronous, active high) clears pending lead bytes, empties the
//   queue and drops rsp_tvalid.
`default_nettype none
module utf8_to_utf16_decoder
   import u2u_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ByteWidth-1:0]  req_tdata,   // [7:0] in_byte
   input  wire logic                  req_tlast,   // end_of_string
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [UnitWidth-1:0]       rsp_tdata,   // [15:0] code_unit
   output logic                       rsp_tlast    // last_unit
);

   logic      accept;
   logic      push, pop, q_full, q_empty;
   entry_type push_entry, head;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   u2u_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_tdata),
      .end_of_string (req_tlast),
      .push          (push),
      .push_entry    (push_entry)
   );

   u2u_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (push_entry),
      .full    (q_full),
      .rd_en   (pop),
      .rd_data (head),
      .empty   (q_empty)
   );

   u2u_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_empty),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_unit   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ hdl/u2u_front.sv @@
// Front part: accepts bytes, tracks pending lead bytes and classifies each item.
`default_nettype none
module u2u_front
   import u2u_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [ByteWidth-1:0] in_byte,
   input  wire logic                 end_of_string,
   output logic                      push,
   output entry_type                 push_entry
);

   logic [1:0]           held_count_ff, held_count_in;
   logic [ByteWidth-1:0] held_lead_ff, held_lead_in;
   logic [ByteWidth-1:0] held_second_ff, held_second_in;

   always_comb begin
      held_count_in     = held_count_ff;
      held_lead_in      = held_lead_ff;
      held_second_in    = held_second_ff;
      push              = 1'b0;
      push_entry.op     = OP_LONE;
      push_entry.lead   = held_lead_ff;
      push_entry.second = held_second_ff;
      push_entry.data   = in_byte;
      push_entry.last   = end_of_string;
      if (accept) begin
         case (held_count_ff)
            2'd1: begin
               held_count_in = 2'd0;
               if (is_two_lead(held_lead_ff)) begin
                  push          = 1'b1;
                  push_entry.op = OP_TWO;
               end else if (!end_of_string) begin
                  held_second_in = in_byte;
                  held_count_in  = 2'd2;
               end else begin
                  push          = 1'b1;
                  push_entry.op = OP_TRUNC;
               end
            end
            2'd2: begin
               held_count_in = 2'd0;
               push          = 1'b1;
               push_entry.op = OP_THREE;
            end
            default: begin
               held_count_in = 2'd0;
               if ((is_three_lead(in_byte) || is_two_lead(in_byte)) && !end_of_string) begin
                  held_lead_in  = in_byte;
                  held_count_in = 2'd1;
               end else begin
                  // a lead at the end of the string decodes alone to the replacement
                  push          = 1'b1;
                  push_entry.op = OP_LONE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff  <= '0;
         held_lead_ff   <= '0;
         held_second_ff <= '0;
      end else begin
         held_count_ff  <= held_count_in;
         held_lead_ff   <= held_lead_in;
         held_second_ff <= held_second_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/u2u_queue.sv @@
// Small FIFO of classified items between the front and the back.
`default_nettype none
module u2u_queue
   import u2u_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_en,
   input  wire entry_type  wr_data,
   output logic            full,
   input  wire logic       rd_en,
   output entry_type       rd_data,
   output logic            empty
);

   entry_type                  slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrWidth:0]     count_ff, count_in;

   assign full    = count_ff == (QueuePtrWidth+1)'(QueueDepth);
   assign empty   = count_ff == '0;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/u2u_back.sv @@
// Back part: builds code units from queued items into the output register.
`default_nettype none
module u2u_back
   import u2u_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire entry_type            head,
   input  wire logic                 head_valid,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [UnitWidth-1:0]      rsp_unit,
   output logic                      rsp_last
);

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [UnitWidth-1:0] rsp_unit_ff, rsp_unit_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 phase_ff, phase_in;
   logic                 load;
   logic [UnitWidth-1:0] lone_unit;

   assign load      = head_valid && (!rsp_valid_ff || rsp_ready);
   assign lone_unit = head.data[7] ? REPLACEMENT_UNIT : {8'h00, head.data};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_unit_in  = rsp_unit_ff;
      rsp_last_in  = rsp_last_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = head.last;
         pop          = 1'b1;
         phase_in     = 1'b0;
         unique case (head.op)
            OP_TWO:   rsp_unit_in = {5'd0, head.lead[4:0], head.data[5:0]};
            OP_THREE: rsp_unit_in = {head.lead[3:0], head.second[5:0], head.data[5:0]};
            OP_TRUNC: begin
               // first the replacement for the lead, then on the next load the lone final byte
               if (!phase_ff) begin
                  rsp_unit_in = REPLACEMENT_UNIT;
                  rsp_last_in = 1'b0;
                  pop         = 1'b0;
                  phase_in    = 1'b1;
               end else begin
                  rsp_unit_in = lone_unit;
               end
            end
            default:  rsp_unit_in = lone_unit;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_unit_ff <= rsp_unit_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_unit  = rsp_unit_ff;
   assign rsp_last  = rsp_last_ff;

endmodule
`default_nettype wire
